// ----- sv/ccd_pkg.sv -----
// ----------------------------------------------------------------------------
// Coin change dispenser package
// Shared types, status codes, coin values and the multiple-of-five check.
// ----------------------------------------------------------------------------
package ccd_pkg;

	// Largest coin count that a fill write may load.
	localparam int COIN_STOCK_MAX = 255;

	// Coin and bill values in cents.
	localparam logic [6:0] BILL_CENTS     = 7'd100;
	localparam logic [5:0] QUARTER_CENTS  = 6'd25;
	localparam logic [5:0] QUARTER2_CENTS = 6'd50;
	localparam logic [5:0] DIME_CENTS     = 6'd10;
	localparam logic [5:0] NICKEL_CENTS   = 6'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_FILL_QUARTERS = 2'd0;
	localparam logic [1:0] REG_FILL_DIMES    = 2'd1;
	localparam logic [1:0] REG_FILL_NICKELS  = 2'd2;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_RANGE = 3'd1,
		ST_MULT5 = 3'd2,
		ST_SHORT = 3'd3,
		ST_ZERO  = 3'd4
	} status_t;

	// Coin stock held in the machine.
	typedef struct packed {
		logic [7:0] quarters;
		logic [7:0] dimes;
		logic [7:0] nickels;
	} stock_t;

	// One finished transaction as produced by the sequencer.
	typedef struct packed {
		status_t    status;
		logic [6:0] change;
		logic [2:0] quarters;
		logic [3:0] dimes;
		logic [4:0] nickels;
	} txn_res_t;

	// Sequencer status toward the top level.
	typedef struct packed {
		logic     idle;
		logic     done;
		txn_res_t res;
	} seq_stat_t;

	// Since 16 is 1 modulo 5, folding nibbles keeps the residue modulo 5.
	function automatic logic is_mult5(input logic [7:0] v);
		logic [4:0] s1;
		logic [4:0] s2;
		logic [3:0] s3;
		s1 = {1'b0, v[7:4]} + {1'b0, v[3:0]};
		s2 = {4'd0, s1[4]} + {1'b0, s1[3:0]};
		s3 = 4'({3'd0, s2[4]} + {1'b0, s2[3:0]});
		return s3 inside {4'd0, 4'd5, 4'd10, 4'd15};
	endfunction

endpackage

// ----- sv/ccd_alu.sv -----
// ----------------------------------------------------------------------------
// Coin change dispenser adder and compare unit
// Adds one coin value to the running sum and compares against the change.
// ----------------------------------------------------------------------------
module ccd_alu (
	input  logic [7:0] sum,
	input  logic [5:0] inc,
	input  logic [6:0] amt,
	output logic [7:0] next,
	output logic       le,
	output logic       lt,
	output logic       eq
);

	// The sum never exceeds the change plus two quarters, so 8 bits hold it.
	assign next = sum + {2'd0, inc};
	assign le   = next <= {1'b0, amt};
	assign lt   = next < {1'b0, amt};
	assign eq   = sum == {1'b0, amt};

endmodule

// ----- sv/ccd_seq.sv -----
// ----------------------------------------------------------------------------
// Coin change dispenser sequencer
// Checks the price, then adds one coin or quarter pair at a time through
// the shared adder, with a greedy pass and an odd-nickel fallback pass.
// ----------------------------------------------------------------------------
module ccd_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [7:0]          price,
	input  ccd_pkg::stock_t     stock,
	input  logic                ack,
	output ccd_pkg::seq_stat_t  stat
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_EVAL = 9'b000000010,
		S_GQ   = 9'b000000100,
		S_GD   = 9'b000001000,
		S_GN   = 9'b000010000,
		S_CHK  = 9'b000100000,
		S_FQ1  = 9'b001000000,
		S_FQ2  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [7:0]        price_q;
	logic [6:0]        amt_q;
	logic [7:0]        sum_q;
	logic [2:0]        q_q;
	logic [3:0]        d_q;
	logic [4:0]        n_q;
	logic              fb_q;
	ccd_pkg::status_t  status_q;

	logic [5:0] inc;
	logic [7:0] next;
	logic       le;
	logic       lt;
	logic       eq;
	logic       q_left;
	logic       q2_left;
	logic       d_left;
	logic       n_left;

	// Coin value fed to the shared adder in each phase.
	always_comb begin
		case (state_q)
			S_GQ, S_FQ1: inc = ccd_pkg::QUARTER_CENTS;
			S_FQ2:       inc = ccd_pkg::QUARTER2_CENTS;
			S_GD:        inc = ccd_pkg::DIME_CENTS;
			default:     inc = ccd_pkg::NICKEL_CENTS;
		endcase
	end

	ccd_alu u_alu (
		.sum  (sum_q),
		.inc  (inc),
		.amt  (amt_q),
		.next (next),
		.le   (le),
		.lt   (lt),
		.eq   (eq)
	);

	// Stock limits on the coins taken so far.
	assign q_left  = {5'd0, q_q} != stock.quarters;
	assign q2_left = ({5'd0, q_q} + 8'd2) <= stock.quarters;
	assign d_left  = {4'd0, d_q} != stock.dimes;
	assign n_left  = {3'd0, n_q} != stock.nickels;

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						price_q <= price;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					sum_q <= 8'd0;
					q_q   <= 3'd0;
					d_q   <= 4'd0;
					n_q   <= 5'd0;
					fb_q  <= 1'b0;
					amt_q <= 7'd0;
					if (price_q > {1'b0, ccd_pkg::BILL_CENTS}) begin
						status_q <= ccd_pkg::ST_RANGE;
						state_q  <= S_DONE;
					end else if (!ccd_pkg::is_mult5(price_q)) begin
						status_q <= ccd_pkg::ST_MULT5;
						state_q  <= S_DONE;
					end else if (price_q == 8'd0) begin
						status_q <= ccd_pkg::ST_ZERO;
						state_q  <= S_DONE;
					end else begin
						amt_q   <= ccd_pkg::BILL_CENTS - price_q[6:0];
						state_q <= S_GQ;
					end
				end
				S_GQ: begin
					if (le && q_left) begin
						sum_q <= next;
						q_q   <= q_q + 3'd1;
					end else begin
						state_q <= S_GD;
					end
				end
				S_GD: begin
					if (le && d_left) begin
						sum_q <= next;
						d_q   <= d_q + 4'd1;
					end else begin
						state_q <= S_GN;
					end
				end
				S_GN: begin
					if (le && n_left) begin
						sum_q <= next;
						n_q   <= n_q + 5'd1;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (eq) begin
						status_q <= ccd_pkg::ST_OK;
						state_q  <= S_DONE;
					end else if (!fb_q && amt_q[0]) begin
						// Odd count of nickels: retry with the fallback order.
						sum_q   <= 8'd0;
						q_q     <= 3'd0;
						d_q     <= 4'd0;
						n_q     <= 5'd0;
						fb_q    <= 1'b1;
						state_q <= S_FQ1;
					end else begin
						status_q <= ccd_pkg::ST_SHORT;
						q_q      <= 3'd0;
						d_q      <= 4'd0;
						n_q      <= 5'd0;
						state_q  <= S_DONE;
					end
				end
				S_FQ1: begin
					if (lt && q_left) begin
						sum_q <= next;
						q_q   <= q_q + 3'd1;
					end
					state_q <= S_FQ2;
				end
				S_FQ2: begin
					if (lt && q2_left) begin
						sum_q <= next;
						q_q   <= q_q + 3'd2;
					end else begin
						state_q <= S_GD;
					end
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle         = state_q == S_IDLE;
	assign stat.done         = state_q == S_DONE;
	assign stat.res.status   = status_q;
	assign stat.res.change   = amt_q;
	assign stat.res.quarters = q_q;
	assign stat.res.dimes    = d_q;
	assign stat.res.nickels  = n_q;

endmodule

// ----- sv/coin_change_dispenser_unit.sv -----
// ----------------------------------------------------------------------------
// Coin change dispenser
// Takes a purchase price paid with a one-dollar bill and pays the change
// from the quarter, dime and nickel stock.
// ----------------------------------------------------------------------------
//
// Channel | Signals                                   | Direction
// --------+-------------------------------------------+----------
// input   | in_valid, in_ready, price_cents           | in
// result  | out_valid, out_ready, status, change_cents,| out
//         | quarters_out, dimes_out, nickels_out,      |
//         | valid_count                                |
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A price adds one coin or quarter pair per cycle through the shared adder,
// plus a step to close each phase; a rejected price skips the coin phases.
// Reset clears the coin stock, the transaction count and the result register.
// in_ready is high only while the sequencer is idle; a finished result may
// wait in the output register while the next price is taken.
// A stalled output holds the sequencer in its done step until the register
// frees up. Configuration writes are always taken.
//
module coin_change_dispenser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  price_cents,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [6:0]  change_cents,
	output logic [2:0]  quarters_out,
	output logic [3:0]  dimes_out,
	output logic [4:0]  nickels_out,
	output logic [15:0] valid_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	ccd_pkg::stock_t    stock_q;
	logic [15:0]        done_cnt_q;
	ccd_pkg::seq_stat_t stat;
	ccd_pkg::txn_res_t  res_q;
	logic [15:0]        count_q;
	logic               out_valid_q;
	logic               ack;
	logic               finish;
	logic               start;
	logic               cfg_write;
	logic [7:0]         fill_val;

	assign in_ready  = stat.idle;
	assign start     = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign ack       = !out_valid_q || out_ready;
	assign finish    = stat.done && ack;

	ccd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.price  (price_cents),
		.stock  (stock_q),
		.ack    (ack),
		.stat   (stat)
	);

	// Loaded coin count, limited to the stock maximum.
	assign fill_val = (32'(cfg_data) > ccd_pkg::COIN_STOCK_MAX) ?
		8'(ccd_pkg::COIN_STOCK_MAX) : cfg_data;

	// Coin stock: a fill write loads it, else a successful sale reduces it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stock_q    <= '0;
			done_cnt_q <= 16'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				ccd_pkg::REG_FILL_QUARTERS: stock_q.quarters <= fill_val;
				ccd_pkg::REG_FILL_DIMES:    stock_q.dimes    <= fill_val;
				ccd_pkg::REG_FILL_NICKELS:  stock_q.nickels  <= fill_val;
				default: ;
			endcase
		end else if (finish && stat.res.status == ccd_pkg::ST_OK) begin
			stock_q.quarters <= stock_q.quarters - {5'd0, stat.res.quarters};
			stock_q.dimes    <= stock_q.dimes - {4'd0, stat.res.dimes};
			stock_q.nickels  <= stock_q.nickels - {3'd0, stat.res.nickels};
			if (done_cnt_q != 16'hFFFF) begin
				done_cnt_q <= done_cnt_q + 16'd1;
			end
		end
	end

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The sequencer already reports no change owed for rejected prices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (finish) begin
			res_q <= stat.res;
		end
	end

	// Count as of this transaction, including its own increment.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd0;
		end else if (finish) begin
			if (stat.res.status == ccd_pkg::ST_OK && done_cnt_q != 16'hFFFF) begin
				count_q <= done_cnt_q + 16'd1;
			end else begin
				count_q <= done_cnt_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign change_cents = res_q.change;
	assign quarters_out = res_q.quarters;
	assign dimes_out    = res_q.dimes;
	assign nickels_out  = res_q.nickels;
	assign valid_count  = count_q;

	// The sequencer is busy in the cycle after it takes a price.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("sequencer took a price but stayed idle");

	// Dispensed coins add up to the change owed.
	a_coins_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ccd_pkg::ST_OK) |->
		(8'(quarters_out) * 8'd25 + 8'(dimes_out) * 8'd10 + 8'(nickels_out) * 8'd5
			== {1'b0, change_cents}))
		else $error("dispensed coins do not match the change");

	// No coins leave the machine unless the transaction succeeded.
	a_no_coins_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ccd_pkg::ST_OK) |->
		(quarters_out == 3'd0 && dimes_out == 4'd0 && nickels_out == 5'd0))
		else $error("coins reported on a failed transaction");

	// The transaction count only ever steps up by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done_cnt_q != $past(done_cnt_q)) |-> (done_cnt_q == $past(done_cnt_q) + 16'd1))
		else $error("transaction count jumped");

endmodule

// ----- tb/sv/ccd_sale_checker.sv -----
// ----------------------------------------------------------------------------
// Coin change dispenser result checker
// Watches the price, result and fill-register channels of the dispenser. It
// keeps its own copy of the coin stock and the sale count, works out the
// expected result of every accepted price, and compares each result transfer
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module ccd_sale_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  price_cents,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [6:0]  change_cents,
	input  logic [2:0]  quarters_out,
	input  logic [3:0]  dimes_out,
	input  logic [4:0]  nickels_out,
	input  logic [15:0] valid_count,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          sales_in_flight,
	output int          sales_checked,
	output int          sales_paid,
	output int          sales_short
);

	// One expected result of a purchase.
	typedef struct {
		ccd_pkg::status_t status;
		logic [6:0]       change;
		logic [2:0]       quarters;
		logic [3:0]       dimes;
		logic [4:0]       nickels;
		logic [15:0]      count;
	} sale_t;

	// Expected results in the order the prices were taken.
	sale_t pending_sales[$];

	// Shadow of the machine's coin stock and sale count.
	logic [7:0]  quarter_stock;
	logic [7:0]  dime_stock;
	logic [7:0]  nickel_stock;
	logic [15:0] done_count;

	// Tries to pay the owed amount from stock: greedy first, then the
	// quarter-pair fallback when the amount is an odd multiple of five.
	function automatic bit make_change(input int owed, output int nq, output int nd,
			output int nn);
		int paid;
		paid = 0;
		nq = 0;
		nd = 0;
		nn = 0;
		while (paid + ccd_pkg::QUARTER_CENTS <= owed && nq != int'(quarter_stock)) begin
			paid += ccd_pkg::QUARTER_CENTS;
			nq++;
		end
		if (paid != owed)
			while (paid + ccd_pkg::DIME_CENTS <= owed && nd != int'(dime_stock)) begin
				paid += ccd_pkg::DIME_CENTS;
				nd++;
			end
		if (paid != owed)
			while (paid + ccd_pkg::NICKEL_CENTS <= owed && nn != int'(nickel_stock)) begin
				paid += ccd_pkg::NICKEL_CENTS;
				nn++;
			end
		if (paid != owed && (owed % ccd_pkg::DIME_CENTS) != 0) begin
			paid = 0;
			nq = 0;
			nd = 0;
			nn = 0;
			if (paid + ccd_pkg::QUARTER_CENTS < owed && nq != int'(quarter_stock)) begin
				paid += ccd_pkg::QUARTER_CENTS;
				nq++;
			end
			if (nq != int'(quarter_stock))
				while (paid + ccd_pkg::QUARTER2_CENTS < owed
						&& nq + 2 <= int'(quarter_stock)) begin
					paid += ccd_pkg::QUARTER2_CENTS;
					nq += 2;
				end
			while (paid + ccd_pkg::DIME_CENTS <= owed && nd != int'(dime_stock)) begin
				paid += ccd_pkg::DIME_CENTS;
				nd++;
			end
			if (paid != owed)
				while (paid + ccd_pkg::NICKEL_CENTS <= owed && nn != int'(nickel_stock)) begin
					paid += ccd_pkg::NICKEL_CENTS;
					nn++;
				end
		end
		return paid == owed;
	endfunction

	// Works out the result of one price and updates stock and count on a sale.
	function automatic sale_t settle_purchase(input logic [7:0] price);
		sale_t s;
		int owed;
		int nq;
		int nd;
		int nn;
		s.status = ccd_pkg::ST_OK;
		s.change = '0;
		s.quarters = '0;
		s.dimes = '0;
		s.nickels = '0;
		if (price > ccd_pkg::BILL_CENTS) begin
			s.status = ccd_pkg::ST_RANGE;
		end else if ((price % ccd_pkg::NICKEL_CENTS) != 0) begin
			s.status = ccd_pkg::ST_MULT5;
		end else if (price == 0) begin
			s.status = ccd_pkg::ST_ZERO;
		end else begin
			owed = ccd_pkg::BILL_CENTS - price;
			s.change = 7'(owed);
			if (make_change(owed, nq, nd, nn)) begin
				quarter_stock -= 8'(nq);
				dime_stock -= 8'(nd);
				nickel_stock -= 8'(nn);
				if (done_count != 16'hFFFF)
					done_count++;
				s.quarters = 3'(nq);
				s.dimes = 4'(nd);
				s.nickels = 5'(nn);
			end else begin
				s.status = ccd_pkg::ST_SHORT;
			end
		end
		s.count = done_count;
		return s;
	endfunction

	// Compares one result field and counts a mismatch.
	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Follow register writes, predict on price transfers, check on result
	// transfers.
	always @(posedge clk or negedge arst_n) begin
		sale_t want;
		if (!arst_n) begin
			pending_sales.delete();
			quarter_stock = '0;
			dime_stock = '0;
			nickel_stock = '0;
			done_count = '0;
			mismatches = 0;
			sales_checked = 0;
			sales_paid = 0;
			sales_short = 0;
			sales_in_flight <= 0;
		end else begin
			// A fill write loads the stock, limited to the largest count.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ccd_pkg::REG_FILL_QUARTERS: begin
						quarter_stock = (cfg_data > ccd_pkg::COIN_STOCK_MAX) ?
							8'(ccd_pkg::COIN_STOCK_MAX) : cfg_data;
					end
					ccd_pkg::REG_FILL_DIMES: begin
						dime_stock = (cfg_data > ccd_pkg::COIN_STOCK_MAX) ?
							8'(ccd_pkg::COIN_STOCK_MAX) : cfg_data;
					end
					ccd_pkg::REG_FILL_NICKELS: begin
						nickel_stock = (cfg_data > ccd_pkg::COIN_STOCK_MAX) ?
							8'(ccd_pkg::COIN_STOCK_MAX) : cfg_data;
					end
					default: begin
					end
				endcase
			end

			if (in_valid && in_ready)
				pending_sales.push_back(settle_purchase(price_cents));

			if (out_valid && out_ready) begin
				if (pending_sales.size() == 0) begin
					$error("result transfer with no purchase waiting (status %0d)", status);
					mismatches++;
				end else begin
					want = pending_sales.pop_front();
					check_field("status", 16'(want.status), 16'(status));
					check_field("change_cents", 16'(want.change), 16'(change_cents));
					check_field("quarters_out", 16'(want.quarters), 16'(quarters_out));
					check_field("dimes_out", 16'(want.dimes), 16'(dimes_out));
					check_field("nickels_out", 16'(want.nickels), 16'(nickels_out));
					check_field("valid_count", want.count, valid_count);
					sales_checked++;
					if (want.status == ccd_pkg::ST_OK)
						sales_paid++;
					if (want.status == ccd_pkg::ST_SHORT)
						sales_short++;
				end
			end
			sales_in_flight <= pending_sales.size();
		end
	end

endmodule

// ----- tb/sv/tb_coin_change_dispenser_unit.sv -----
// ----------------------------------------------------------------------------
// Coin change dispenser testbench
// Drives purchase prices and fill-register writes into the dispenser under
// several idle and stall patterns, and lets the result checker compare every
// result against its own prediction of the coin stock and sale count.
// ----------------------------------------------------------------------------
module tb_coin_change_dispenser_unit;

	// Index past the last fill register; writes to it are ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  price_cents;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [6:0]  change_cents;
	logic [2:0]  quarters_out;
	logic [3:0]  dimes_out;
	logic [4:0]  nickels_out;
	logic [15:0] valid_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	int mismatches;
	int sales_in_flight;
	int sales_checked;
	int sales_paid;
	int sales_short;

	// Percent of cycles the price side idles and the result side stalls.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	coin_change_dispenser_unit dut (.*);

	ccd_sale_checker checker_i (.*);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// Result side back-pressure.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Offers one price, with an optional idle gap first, and waits for the
	// transfer.
	task automatic buy(input logic [7:0] price);
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		in_valid <= 1'b1;
		price_cents <= price;
		do @(posedge clk); while (!in_ready);
	endtask

	// One register write transfer; the caller lowers cfg_valid afterward.
	task automatic load(input logic [1:0] index, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Waits until every expected result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sales_in_flight != 0)
			@(posedge clk);
	endtask

	// Reloads all three coin stocks once the machine is idle.
	task automatic restock(input logic [7:0] q, input logic [7:0] d, input logic [7:0] n);
		settle();
		load(ccd_pkg::REG_FILL_QUARTERS, q);
		load(ccd_pkg::REG_FILL_DIMES, d);
		load(ccd_pkg::REG_FILL_NICKELS, n);
		load(REG_UNUSED, 8'($urandom_range(255)));
		cfg_valid <= 1'b0;
	endtask

	// Stock level from one of several profiles: nearly empty, any, full, extremes.
	function automatic logic [7:0] pick_fill(input int profile);
		if (profile == 0)
			return 8'($urandom_range(6));
		if (profile == 1)
			return 8'($urandom_range(255));
		if (profile == 2)
			return 8'd255;
		case ($urandom_range(2))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(3));
		endcase
	endfunction

	// Mostly valid prices, with some zero, out-of-range and arbitrary bytes.
	function automatic logic [7:0] pick_price();
		int r;
		r = $urandom_range(99);
		if (r < 72)
			return 8'(ccd_pkg::NICKEL_CENTS * $urandom_range(1, 20));
		if (r < 76)
			return 8'd0;
		if (r < 84)
			return 8'($urandom_range(101, 255));
		return 8'($urandom_range(255));
	endfunction

	initial begin
		int mode;
		int chunk;
		int k;
		int profile;
		arst_n = 1'b0;
		in_valid = 1'b0;
		price_cents = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty machine: every rejection, a sale with no change, a short sale.
		buy(8'd0);
		buy(8'd101);
		buy(8'd255);
		buy(8'd7);
		buy(8'd99);
		buy(8'd128);
		buy(8'd100);
		buy(8'd5);

		// Stock where greedy fails but one quarter plus dimes pays.
		restock(8'd3, 8'd4, 8'd0);
		buy(8'd35);
		buy(8'd5);

		// The quarter-pair fallback runs and still comes up short.
		restock(8'd3, 8'd1, 8'd0);
		buy(8'd5);

		// Full stock: the usual coin mixes.
		restock(8'd255, 8'd255, 8'd255);
		buy(8'd5);
		buy(8'd10);
		buy(8'd45);
		buy(8'd55);
		buy(8'd95);
		buy(8'd20);
		buy(8'd50);

		// Largest dime and nickel payouts.
		restock(8'd0, 8'd9, 8'd1);
		buy(8'd5);
		restock(8'd0, 8'd0, 8'd19);
		buy(8'd5);

		// Random purchases in small batches, restocked between batches.
		for (mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 83;
				end
				default: begin
					send_gap_pct = 7;
					recv_stall_pct = 7;
				end
			endcase
			for (chunk = 0; chunk < 30; chunk++) begin
				profile = $urandom_range(3);
				restock(pick_fill(profile), pick_fill(profile), pick_fill(profile));
				for (k = 0; k < 15; k++)
					buy(pick_price());
			end
		end

		settle();
		recv_stall_pct = 0;
		repeat (60) @(posedge clk);

		$display("Checked %0d purchases (%0d paid out, %0d short of change)",
			sales_checked, sales_paid, sales_short);
		$display("over random restocks with and without idle and stall cycles.");
		if (mismatches == 0 && sales_in_flight == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/ccd_pkg.sv
sv/ccd_alu.sv
sv/ccd_seq.sv
sv/coin_change_dispenser_unit.sv
tb/sv/ccd_sale_checker.sv
tb/sv/tb_coin_change_dispenser_unit.sv
